### rtl/core/stxf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxf_pkg
// Shared types and constants for the STX/ETX checksum framer.
// ----------------------------------------------------------------------------
package stxf_pkg;

    // Frame bytes
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    // Longest payload a header may announce
    localparam logic [7:0] MAX_PAYLOAD = 8'd31;

    // Longest run of bytes one request can produce
    localparam int RUN_MAX = 6;
    localparam int CNT_W   = $clog2(RUN_MAX + 1);
    localparam int IDX_W   = $clog2(RUN_MAX);

    // Request selector codes
    typedef enum logic [1:0] {
        REQ_HEADER = 2'd0,
        REQ_DATA   = 2'd1,
        REQ_SHORT  = 2'd2
    } t_req_type;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_LEN_TOO_LARGE = 2'd1,
        ST_NO_FRAME      = 2'd2
    } t_status;

    // One captured request
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] cmd;
        logic [7:0] payload_len;
        logic [7:0] data_a;
        logic [7:0] data_b;
    } t_req;

    // Run of result bytes built from one request
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic                    closes;   // last byte is the closing ETX
        t_status                 status;
    } t_run;

endpackage

### rtl/core/stxf_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxf_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface stxf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] cmd;
    logic [7:0] payload_len;
    logic [7:0] data_a;
    logic [7:0] data_b;

    modport source (
        output valid, req_type, cmd, payload_len, data_a, data_b,
        input  ready
    );
    modport sink (
        input  valid, req_type, cmd, payload_len, data_a, data_b,
        output ready
    );
endinterface

### rtl/core/stxf_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxf_res_if
// Result channel: valid/ready handshake with one frame byte and its flags.
// ----------------------------------------------------------------------------
interface stxf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_of_run;
    logic       frame_done;
    logic [1:0] status;

    modport source (
        output valid, tx_byte, last_of_run, frame_done, status,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, last_of_run, frame_done, status,
        output ready
    );
endinterface

### rtl/core/stx_etx_checksum_framer_unit.sv
`timescale 1ns / 1ps
// First result byte of a request: valid once the request has passed the input
//   register and then the result register. Throughput: one result byte per cycle
//   while o_res.ready is high; 0 to 6 bytes per request, via the serializer's one port.
// A request that yields no bytes still passes through the input register.
// Reset (synchronous, active low) closes any frame, clears length and checksum
//   state, and empties the input and result registers.
// ----------------------------------------------------------------------------
// stx_etx_checksum_framer_unit
// Builds STX/length/cmd/data/checksum/ETX frames and short STX/cmd/data/data/checksum/ETX frames for a serial link.
// ----------------------------------------------------------------------------
module stx_etx_checksum_framer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stxf_req_if.sink   i_req,
    stxf_res_if.source o_res
);

    logic           run_valid;
    logic           load;
    stxf_pkg::t_run run;

    // Request capture, frame state and run building
    stxf_frame_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_load      (load),
        .o_run_valid (run_valid),
        .o_run       (run)
    );

    // Byte-by-byte output of each run
    stxf_run_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (run_valid),
        .i_run       (run),
        .o_load      (load),
        .o_res       (o_res)
    );

endmodule

### rtl/core/stxf_frame_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxf_frame_engine
// Input register plus frame state; builds the byte run for the held request.
// ----------------------------------------------------------------------------
module stxf_frame_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stxf_req_if.sink      i_req,
    input  logic          i_load,       // run taken by the serializer
    output logic          o_run_valid,
    output stxf_pkg::t_run o_run
);

    logic          r_in_valid;
    stxf_pkg::t_req r_in;

    logic       r_frame_open, n_frame_open;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_running_sum, n_running_sum;

    logic       in_xfer;
    logic [7:0] lenp1;
    logic [7:0] hdr_sum;
    logic [7:0] dat_sum;
    logic [7:0] left_dec;
    logic [7:0] short_sum;

    // Input register: refilled as soon as its request moves on
    assign i_req.ready = !r_in_valid || i_load;
    assign in_xfer     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (i_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.req_type    <= i_req.req_type;
            r_in.cmd         <= i_req.cmd;
            r_in.payload_len <= i_req.payload_len;
            r_in.data_a      <= i_req.data_a;
            r_in.data_b      <= i_req.data_b;
        end
    end

    // Checksum arithmetic, all mod 256
    assign lenp1     = r_in.payload_len + 8'd1;
    assign hdr_sum   = stxf_pkg::STX_BYTE + lenp1 + r_in.cmd;
    assign dat_sum   = r_running_sum + r_in.data_a;
    assign left_dec  = r_bytes_left - 8'd1;
    assign short_sum = stxf_pkg::STX_BYTE + r_in.cmd + r_in.data_a + r_in.data_b;

    // Run and next frame state for the held request
    always_comb begin
        o_run         = '0;
        o_run.status  = stxf_pkg::ST_OK;
        n_frame_open  = r_frame_open;
        n_bytes_left  = r_bytes_left;
        n_running_sum = r_running_sum;
        unique case (stxf_pkg::t_req_type'(r_in.req_type))
            stxf_pkg::REQ_HEADER: begin
                if (r_in.payload_len > stxf_pkg::MAX_PAYLOAD) begin
                    o_run.count   = stxf_pkg::CNT_W'(1);
                    o_run.status  = stxf_pkg::ST_LEN_TOO_LARGE;
                    n_frame_open  = 1'b0;
                    n_bytes_left  = 8'd0;
                    n_running_sum = 8'd0;
                end else begin
                    o_run.bytes[0] = stxf_pkg::STX_BYTE;
                    o_run.bytes[1] = lenp1;
                    o_run.bytes[2] = r_in.cmd;
                    o_run.bytes[3] = hdr_sum;
                    o_run.bytes[4] = stxf_pkg::ETX_BYTE;
                    if (r_in.payload_len == 8'd0) begin
                        // empty payload closes the frame at once
                        o_run.count   = stxf_pkg::CNT_W'(5);
                        o_run.closes  = 1'b1;
                        n_frame_open  = 1'b0;
                        n_bytes_left  = 8'd0;
                        n_running_sum = 8'd0;
                    end else begin
                        o_run.count   = stxf_pkg::CNT_W'(3);
                        n_frame_open  = 1'b1;
                        n_bytes_left  = r_in.payload_len;
                        n_running_sum = hdr_sum;
                    end
                end
            end
            stxf_pkg::REQ_DATA: begin
                if (!r_frame_open) begin
                    o_run.count  = stxf_pkg::CNT_W'(1);
                    o_run.status = stxf_pkg::ST_NO_FRAME;
                end else begin
                    o_run.bytes[0] = r_in.data_a;
                    o_run.bytes[1] = dat_sum;
                    o_run.bytes[2] = stxf_pkg::ETX_BYTE;
                    if (left_dec == 8'd0) begin
                        // last payload byte: checksum and ETX follow
                        o_run.count   = stxf_pkg::CNT_W'(3);
                        o_run.closes  = 1'b1;
                        n_frame_open  = 1'b0;
                        n_bytes_left  = 8'd0;
                        n_running_sum = 8'd0;
                    end else begin
                        o_run.count   = stxf_pkg::CNT_W'(1);
                        n_bytes_left  = left_dec;
                        n_running_sum = dat_sum;
                    end
                end
            end
            stxf_pkg::REQ_SHORT: begin
                // self-contained frame, open frame state untouched
                o_run.bytes[0] = stxf_pkg::STX_BYTE;
                o_run.bytes[1] = r_in.cmd;
                o_run.bytes[2] = r_in.data_a;
                o_run.bytes[3] = r_in.data_b;
                o_run.bytes[4] = short_sum;
                o_run.bytes[5] = stxf_pkg::ETX_BYTE;
                o_run.count    = stxf_pkg::CNT_W'(6);
                o_run.closes   = 1'b1;
            end
            default: begin
                // unused selector: no bytes, no state change
            end
        endcase
    end

    assign o_run_valid = r_in_valid;

    // Frame state commits when the run is handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open  <= 1'b0;
            r_bytes_left  <= 8'd0;
            r_running_sum <= 8'd0;
        end else if (i_load) begin
            r_frame_open  <= n_frame_open;
            r_bytes_left  <= n_bytes_left;
            r_running_sum <= n_running_sum;
        end
    end

endmodule

### rtl/core/stxf_run_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxf_run_serializer
// Result register: holds one byte run and sends it one byte per transfer.
// ----------------------------------------------------------------------------
module stxf_run_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_run_valid,
    input  stxf_pkg::t_run i_run,
    output logic           o_load,
    stxf_res_if.source     o_res
);

    logic                     r_valid;
    stxf_pkg::t_run           r_run;
    logic [stxf_pkg::IDX_W-1:0] r_idx;

    logic last;
    logic take;
    logic can_load;

    assign last     = (stxf_pkg::CNT_W'(r_idx) == (r_run.count - stxf_pkg::CNT_W'(1)));
    assign take     = r_valid && o_res.ready;
    assign can_load = !r_valid || (take && last);
    assign o_load   = i_run_valid && can_load;

    // Run buffer and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_load) begin
            r_valid <= (i_run.count != '0);
            r_idx   <= '0;
        end else if (take) begin
            r_valid <= !last;
            r_idx   <= r_idx + stxf_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_run <= i_run;
        end
    end

    // Output byte and flags
    assign o_res.valid       = r_valid;
    assign o_res.tx_byte     = r_run.bytes[r_idx];
    assign o_res.last_of_run = last;
    assign o_res.frame_done  = last && r_run.closes;
    assign o_res.status      = r_run.status;

endmodule
